// ----- rtl/bdq_pkg.sv -----
// Shared types and codes for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // Operation codes carried by an input word.
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_DISPLAY   = 3'd4;

    // Status codes carried by an output word.
    localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;
        logic start_disp;
        logic rd_en;
        logic send;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic is_display;
        logic empty;
        logic last_entry;
    } t_sts;

endpackage

// ----- rtl/bdq_ctrl.sv -----
// Controller state machine for the bounded double-ended queue.
`timescale 1ns / 1ps

module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = i_sts.out_free;
                if (i_valid && i_sts.out_free) begin
                    // A display of a non-empty queue walks the store entry by entry.
                    if (i_sts.is_display && !i_sts.empty) begin
                        o_cmd.start_disp = 1'b1;
                        n_state          = S_READ;
                    end else begin
                        o_cmd.exec = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.send = 1'b1;
                    n_state    = i_sts.last_entry ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_read_then_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_SEND))
        else $error("read cycle not followed by send");

    a_send_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.send || o_cmd.exec) |-> i_sts.out_free)
        else $error("output register loaded while occupied and stalled");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE))
        else $error("input taken outside idle");
`endif

endmodule

// ----- rtl/bdq_dp.sv -----
// Datapath of the bounded double-ended queue: ring store, pointers and output register.
`timescale 1ns / 1ps

module bdq_dp
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  logic [OP_W-1:0]               i_opcode,
    input  logic signed [VAL_W-1:0]       i_value,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [VAL_W-1:0]       o_value_res,
    output logic [STATUS_W-1:0]           o_status,
    output logic [$clog2(DEPTH+1)-1:0]    o_occupancy,
    output logic                          o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [AW:0]   WRAP      = (AW + 1)'(DEPTH);

    logic signed [VAL_W-1:0] mem [DEPTH];

    logic [AW-1:0]           r_front;
    logic [AW-1:0]           n_front;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [AW-1:0]           r_rd_ptr;
    logic [CW-1:0]           r_remain;
    logic signed [VAL_W-1:0] r_rd_data;
    logic                    r_out_valid;

    logic [AW-1:0]       front_m1;
    logic [AW-1:0]       front_p1;
    logic [AW-1:0]       rd_ptr_p1;
    logic [AW:0]         back_sum;
    logic [AW-1:0]       back_slot;
    logic                full;
    logic                empty;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [STATUS_W-1:0] exec_status;

    assign full      = (r_count == FULL_CNT);
    assign empty     = (r_count == '0);
    assign front_m1  = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign front_p1  = (r_front == LAST_SLOT) ? '0 : r_front + 1'b1;
    assign rd_ptr_p1 = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;

    // The back slot is only used when not full, so the count fits the address width.
    assign back_sum  = {1'b0, r_front} + (AW + 1)'(r_count);
    assign back_slot = (back_sum >= WRAP) ? AW'(back_sum - WRAP) : back_sum[AW-1:0];

    assign o_sts.out_free   = !r_out_valid || !i_stall;
    assign o_sts.is_display = (i_opcode == OP_DISPLAY);
    assign o_sts.empty      = empty;
    assign o_sts.last_entry = (r_remain == CW'(1));

    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        wr_en       = 1'b0;
        wr_addr     = r_front;
        exec_status = STS_DONE;
        if (i_cmd.exec) begin
            case (i_opcode)
                OP_INS_FRONT: begin
                    if (full) begin
                        exec_status = STS_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = front_m1;
                        n_front = front_m1;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_INS_BACK: begin
                    if (full) begin
                        exec_status = STS_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = back_slot;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_DEL_FRONT: begin
                    if (empty) begin
                        exec_status = STS_EMPTY;
                    end else begin
                        n_front = front_p1;
                        n_count = r_count - 1'b1;
                    end
                end
                OP_DEL_BACK: begin
                    if (empty) begin
                        exec_status = STS_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                OP_DISPLAY: begin
                    // Only an empty queue's display reaches this path.
                    exec_status = STS_EMPTY;
                end
                default: begin
                    exec_status = STS_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_remain <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (i_cmd.start_disp) begin
                r_rd_ptr <= r_front;
                r_remain <= r_count;
            end else begin
                if (i_cmd.rd_en) begin
                    r_rd_ptr <= rd_ptr_p1;
                end
                if (i_cmd.send) begin
                    r_remain <= r_remain - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.send) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_value_res <= '0;
            o_status    <= exec_status;
            o_occupancy <= n_count;
            o_last      <= 1'b1;
        end else if (i_cmd.send) begin
            o_value_res <= r_rd_data;
            o_status    <= STS_DONE;
            o_occupancy <= r_count;
            o_last      <= (r_remain == CW'(1));
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= LAST_SLOT)
        else $error("front pointer outside the ring");

    a_remain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remain <= r_count)
        else $error("display walk longer than the queue");
`endif

endmodule

// ----- rtl/bounded_deque.sv -----
// Top level of the bounded double-ended queue.
`timescale 1ns / 1ps

// A double-ended queue of up to DEPTH signed 32-bit words held in a ring memory.
// Each input word carries an opcode: insert at front, insert at back, delete front,
// delete back or display. Insert, delete and unknown opcodes give one output word
// each, and can be issued back to back while the output is not stalled. A display
// of a non-empty queue gives one output word per entry from front to back, with
// o_last on the final one; each entry is a registered memory read, then a load of
// the output register, and the input is held until the last entry is sent. A
// display of an empty queue gives one empty-status word. The output register takes
// a new result at the same edge at which the waiting one is taken, so while a
// result is stalled the input is stalled too.
module bounded_deque
    import bdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [OP_W-1:0]               i_opcode,
    input  logic signed [VAL_W-1:0]       i_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VAL_W-1:0]       o_value_res,
    output logic [STATUS_W-1:0]           o_status,
    output logic [$clog2(DEPTH+1)-1:0]    o_occupancy,
    output logic                          o_last
);

    t_cmd cmd;
    t_sts sts;
    logic ready;

    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_ready (ready)
    );

    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_value_res (o_value_res),
        .o_status    (o_status),
        .o_occupancy (o_occupancy),
        .o_last      (o_last)
    );

    assign o_stall = !ready;

endmodule
